[hdl/rqsa_pkg.sv]
// ----------------------------------------------------------------------------
// Read quality statistics package
// Shared sizes, codes, threshold constants and the error probability tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqsa_pkg;

    localparam int MAX_LEN        = 1024;
    localparam int SYMBOL_COUNT   = 256;
    localparam int PROB_FRAC_BITS = 24;
    localparam int N_THR          = 4;

    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int ROW_W      = $clog2(MAX_LEN);
    localparam int SYM_W      = $clog2(SYMBOL_COUNT);
    localparam int SYM_AW     = ROW_W + SYM_W;
    localparam int LH_DEPTH   = MAX_LEN + 1;
    localparam int BANK_DEPTH = MAX_LEN / 2;
    localparam int BANK_AW    = ROW_W - 1;
    localparam int CNT_W      = 64;
    localparam int LANE_W     = CNT_W * N_THR;
    localparam int ERR_W      = 48;
    localparam int SCORE_W    = 10;
    localparam int OFS_W      = 7;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PW     = $clog2(OUT_DEPTH);
    localparam int OUT_CW     = OUT_PW + 2;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
    localparam logic signed [SCORE_W-1:0] MIN_RESET = 10'sd511;
    localparam logic [OFS_W-1:0] OFFSET_RESET = 7'd33;
    localparam logic REG_ASCII_OFFSET = 1'b0;

    typedef enum logic [1:0] {
        REQ_SYMBOL = 2'd0,
        REQ_EMPTY  = 2'd1,
        REQ_TABLE  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        SEL_LENGTH  = 3'd0,
        SEL_SYMBOL  = 3'd1,
        SEL_ERRSUM  = 3'd2,
        SEL_SCORE   = 3'd3,
        SEL_ERRPASS = 3'd4,
        SEL_CLIPPED = 3'd5
    } sel_t;

    typedef struct packed {
        logic [BANK_AW-1:0] addr;
        logic [N_THR-1:0]   inc;
    } bank_upd_t;

    localparam logic signed [SCORE_W-1:0] SCORE_THR [N_THR] = '{
        10'sd5, 10'sd10, 10'sd15, 10'sd20
    };

    localparam logic [ERR_W-1:0] ERR_ONE = ERR_W'(1) << PROB_FRAC_BITS;
    localparam logic [ERR_W-1:0] ERR_THR [N_THR] = '{
        ERR_ONE, ERR_ONE >> 1, ERR_ONE >> 2, ERR_W'((64'd1 << PROB_FRAC_BITS) + 64'd5) / 10
    };

    localparam logic [63:0] PROB_DIGITS [10] = '{
        64'd1000000000000, 64'd794328234724, 64'd630957344480, 64'd501187233627,
        64'd398107170553, 64'd316227766017, 64'd251188643151, 64'd199526231497,
        64'd158489319246, 64'd125892541179
    };

    localparam logic [63:0] POW10 [13] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
        64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
        64'd100000000000, 64'd1000000000000
    };

    typedef logic [ERR_W-1:0] prob_pos_t [256];
    typedef logic [ERR_W-1:0] prob_neg_t [128];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (&x) ? x : x + CNT_W'(1);
    endfunction

    function automatic logic [LANE_W-1:0] inc_lanes(input logic [LANE_W-1:0] w,
                                                   input logic [N_THR-1:0] m);
        logic [LANE_W-1:0] o;
        o = w;
        for (int t = 0; t < N_THR; t++) begin
            if (m[t]) begin
                o[t*CNT_W +: CNT_W] = sat_inc(w[t*CNT_W +: CNT_W]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    function automatic logic [63:0] scaled_q(input logic [63:0] num, input logic [63:0] den,
                                             input int shift, input logic [63:0] limit);
        logic [127:0] qr;
        logic [63:0]  q;
        logic [63:0]  r;
        logic         done;
        qr   = udivmod(num, den);
        q    = qr[127:64];
        r    = qr[63:0];
        done = 1'b0;
        if (q > limit) begin
            q    = limit;
            done = 1'b1;
        end
        for (int i = 0; i < 64; i++) begin
            if (!done && i < shift) begin
                q = q << 1;
                r = r << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q + 64'd1;
                end
                if (q > limit) begin
                    q    = limit;
                    done = 1'b1;
                end
            end
        end
        return q;
    endfunction

    function automatic logic [ERR_W-1:0] err_prob_f(input int s);
        logic [127:0] qr;
        logic [63:0]  z;
        logic [63:0]  v;
        int           k;
        int           r;
        int           m;
        int           n;
        int           g;
        g = 62 - PROB_FRAC_BITS;
        k = 0;
        n = 0;
        if (s >= 0) begin
            r = s;
            for (int i = 0; i < 26; i++) begin
                if (r >= 10) begin
                    r = r - 10;
                    k = k + 1;
                end
            end
            z = scaled_q(PROB_DIGITS[r], POW10[12], 62, 64'd1 << 62);
            for (int i = 0; i < 26; i++) begin
                if (i < k) begin
                    qr = udivmod(z, 64'd10);
                    z  = qr[127:64];
                end
            end
            v = (z + (64'd1 << (g - 1))) >> g;
            return v[ERR_W-1:0];
        end
        m = -s;
        r = m + 9;
        for (int i = 0; i < 16; i++) begin
            if (r >= 10) begin
                r = r - 10;
                n = n + 1;
            end
        end
        if (n > 12) begin
            return ERR_MAX;
        end
        r = 10 * n - m;
        z = scaled_q(PROB_DIGITS[r], POW10[12-n], PROB_FRAC_BITS + 1, 64'd1 << 50);
        v = (z + 64'd1) >> 1;
        return (v > {16'd0, ERR_MAX}) ? ERR_MAX : v[ERR_W-1:0];
    endfunction

    function automatic prob_pos_t build_pos();
        prob_pos_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = err_prob_f(i);
        end
        return tab;
    endfunction

    function automatic prob_neg_t build_neg();
        prob_neg_t tab;
        for (int i = 0; i < 128; i++) begin
            tab[i] = err_prob_f(-i);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

[hdl/rqsa_ram.sv]
// ----------------------------------------------------------------------------
// Statistics RAM
// Single write, single read synchronous RAM with write-to-read forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqsa_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [DW-1:0] lw_data_reg;
    logic          lw_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && ({1'b0, wr_addr} < (AW+1)'(DEPTH)))
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg       <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= wr_en;
        end
    end

    assign rd_data = (lw_valid_reg && lw_addr_reg == rd_addr_reg) ? lw_data_reg : q_reg;

endmodule

`default_nettype wire

[hdl/rqsa_prob_rom.sv]
// ----------------------------------------------------------------------------
// Error probability ROM
// Registered lookup of the fixed-point error probability of a quality score.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqsa_prob_rom
    import rqsa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [SCORE_W-1:0] score,
    output logic             [ERR_W-1:0]   prob
);

    localparam prob_pos_t POS_TAB = build_pos();
    localparam prob_neg_t NEG_TAB = build_neg();

    logic [SCORE_W-1:0] neg_mag;
    logic [ERR_W-1:0]   prob_reg;

    assign neg_mag = SCORE_W'(-score);

    always_ff @(posedge clk)
    begin
        if (score[SCORE_W-1])
        begin
            prob_reg <= NEG_TAB[neg_mag[6:0]];
        end
        else
        begin
            prob_reg <= POS_TAB[score[7:0]];
        end
    end

    assign prob = prob_reg;

endmodule

`default_nettype wire

[hdl/rqsa_out_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small queue that holds table read results until the receiver takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqsa_out_fifo
    import rqsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [CNT_W-1:0]  push_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [CNT_W-1:0]  m_tdata,
    output logic      [OUT_CW-1:0] count
);

    logic [CNT_W-1:0]  buf_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] wr_ptr_reg;
    logic [OUT_PW-1:0] rd_ptr_reg;
    logic [OUT_CW-1:0] count_reg;
    logic              pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = buf_mem[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PW'(1);
            end
            count_reg <= count_reg + OUT_CW'(push) - OUT_CW'(pop);
        end
    end

endmodule

`default_nettype wire

[hdl/read_quality_statistics_accumulator.sv]
// ----------------------------------------------------------------------------
// Read quality statistics accumulator
// Per-read quality tracking with length, symbol, error and threshold tables.
// ----------------------------------------------------------------------------
// Items enter on the s_ group: tuser carries the request kind, tlast marks the
// final symbol of a read and tdata the symbol and table coordinates. Symbols
// and empty records produce nothing; a table read produces one item on the m_
// group carrying the 64-bit counter or sum.
// One item is accepted every cycle while s_tready is high. Each statistics
// table is a single RAM, or a pair of RAMs split by even and odd position for
// the threshold tables, and every item performs at most one read-modify-write
// per RAM, with the previous write forwarded to the next read.
// A table read result passes through the stage one and stage two registers
// and then the result queue before it appears on the m_ group.
// Results wait in a four-entry queue; when the receiver stalls, s_tready drops
// once the queue and the pipeline hold four results, and nothing is lost.
// After reset a clearing pass writes zero to every RAM entry, one address per
// cycle, during which s_tready is low. The ascii_offset register at byte
// address 0 of the APB port is written and read at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module read_quality_statistics_accumulator
    import rqsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // qual_char, table_select, table_position, table_column
    input  wire logic        s_tlast,
    input  wire logic [1:0]  s_tuser,  // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,  // read_data
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    function automatic bank_upd_t bank_pick(input logic b, input logic fv,
                                            input logic [ROW_W-1:0] frow,
                                            input logic [N_THR-1:0] fmask, input logic ev,
                                            input logic [ROW_W-1:0] erow,
                                            input logic [N_THR-1:0] emask,
                                            input logic [ROW_W-1:0] trow);
        bank_upd_t u;
        u.addr = trow[ROW_W-1:1];
        u.inc  = '0;
        if (fv && frow[0] == b)
        begin
            u.addr = frow[ROW_W-1:1];
            u.inc  = fmask;
        end
        else if (ev && erow[0] == b)
        begin
            u.addr = erow[ROW_W-1:1];
            u.inc  = emask;
        end
        return u;
    endfunction

    // Configuration and clearing.
    logic [OFS_W-1:0]  ascii_offset_reg;
    logic              clearing_reg;
    logic [SYM_AW-1:0] clr_cnt_reg;

    // Per-read state and the clipped-symbol counter.
    logic [POS_W-1:0]          base_pos_reg;
    logic signed [SCORE_W-1:0] min_reg;
    logic [N_THR-1:0]          smask_reg;
    logic [ERR_W-1:0]          err_reg;
    logic [N_THR-1:0]          emask_reg;
    logic [CNT_W-1:0]          clipped_reg;

    // Accept stage.
    logic                      s_acc;
    logic                      is_sym;
    logic                      is_empty;
    logic                      is_tbl;
    logic [SYM_W-1:0]          in_sym;
    logic [2:0]                in_sel;
    logic [POS_W-1:0]          in_tpos;
    logic [7:0]                in_col;
    logic                      clip;
    logic                      take;
    logic                      end_rd;
    logic signed [SCORE_W-1:0] score_s;
    logic signed [SCORE_W-1:0] min_new;
    logic [N_THR-1:0]          above;
    logic [N_THR-1:0]          smask_new;
    logic [N_THR-1:0]          sfail;
    logic [POS_W-1:0]          len;
    logic [ROW_W-1:0]          len_row;
    logic [ROW_W-1:0]          pos_row;
    logic [ROW_W-1:0]          prev_row;
    logic                      in_range;
    logic [POS_W-1:0]          lh_rd_addr;
    logic [SYM_AW-1:0]         sym_rd_addr;
    bank_upd_t                 sbank_upd [2];

    // Stage one registers.
    logic              s1_tbl_reg;
    logic              s1_take_reg;
    logic              s1_end_reg;
    logic              s1_lh_inc_reg;
    bank_upd_t         s1_sbank_reg [2];
    sel_t              s1_sel_reg;
    logic              s1_inr_reg;
    logic [1:0]        s1_col_reg;
    logic [ROW_W-1:0]  s1_tpos_row_reg;
    logic [ROW_W-1:0]  s1_pos_row_reg;
    logic              s1_pos_nz_reg;
    logic [ROW_W-1:0]  s1_len_row_reg;
    logic [POS_W-1:0]  s1_lh_addr_reg;
    logic [SYM_AW-1:0] s1_sym_addr_reg;
    logic [CNT_W-1:0]  s1_clip_reg;

    // Stage one logic.
    logic [ERR_W-1:0]  prob;
    logic [ERR_W:0]    e_sum;
    logic [ERR_W-1:0]  e_new;
    logic [N_THR-1:0]  below;
    logic [N_THR-1:0]  emask_new;
    logic [N_THR-1:0]  efail;
    logic [ROW_W-1:0]  pes_rd_addr;
    bank_upd_t         ebank_upd [2];
    logic [CNT_W-1:0]  lh_rd;
    logic [CNT_W-1:0]  sym_rd;
    logic [LANE_W-1:0] sb_rd [2];
    logic [LANE_W-1:0] sb_sel;
    logic [CNT_W-1:0]  early;

    // Stage two registers.
    logic              s2_tbl_reg;
    logic              s2_pes_we_reg;
    bank_upd_t         s2_ebank_reg [2];
    sel_t              s2_sel_reg;
    logic              s2_inr_reg;
    logic [1:0]        s2_col_reg;
    logic              s2_trow0_reg;
    logic [CNT_W-1:0]  s2_early_reg;
    logic [ROW_W-1:0]  s2_pes_addr_reg;
    logic [ERR_W-1:0]  s2_err_reg;

    // Stage two logic.
    logic [CNT_W-1:0]  pes_rd;
    logic [CNT_W:0]    pes_sum;
    logic [CNT_W-1:0]  pes_new;
    logic [LANE_W-1:0] eb_rd [2];
    logic [LANE_W-1:0] eb_sel;
    logic [CNT_W-1:0]  result;
    logic [OUT_CW-1:0] fifo_count;
    logic [OUT_CW-1:0] in_flight;

    // ------------------------------------------------------------------------
    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ASCII_OFFSET) ? {25'd0, ascii_offset_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_offset_reg <= OFFSET_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ASCII_OFFSET)
        begin
            ascii_offset_reg <= pwdata[OFS_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Accept stage.
    assign in_flight = OUT_CW'(s1_tbl_reg) + OUT_CW'(s2_tbl_reg) + fifo_count;
    assign s_tready  = !clearing_reg && (in_flight < OUT_CW'(OUT_DEPTH));
    assign s_acc     = s_tvalid && s_tready;
    assign in_sym    = s_tdata[7:0];
    assign in_sel    = s_tdata[10:8];
    assign in_tpos   = s_tdata[21:11];
    assign in_col    = s_tdata[29:22];
    assign is_sym    = s_acc && req_t'(s_tuser) == REQ_SYMBOL;
    assign is_empty  = s_acc && req_t'(s_tuser) == REQ_EMPTY;
    assign is_tbl    = s_acc && req_t'(s_tuser) == REQ_TABLE;

    assign clip      = base_pos_reg == POS_W'(MAX_LEN);
    assign take      = is_sym && !clip;
    assign end_rd    = is_sym && s_tlast;
    assign score_s   = $signed({2'b00, in_sym}) - $signed({3'b000, ascii_offset_reg});
    assign min_new   = (score_s < min_reg) ? score_s : min_reg;
    assign smask_new = smask_reg & above;
    assign sfail     = smask_reg & ~smask_new;
    assign len       = clip ? base_pos_reg : base_pos_reg + POS_W'(1);
    assign len_row   = ROW_W'(len - POS_W'(1));
    assign pos_row   = base_pos_reg[ROW_W-1:0];
    assign prev_row  = ROW_W'(base_pos_reg - POS_W'(1));

    always_comb
    begin
        for (int t = 0; t < N_THR; t++)
        begin
            above[t] = min_new > SCORE_THR[t];
        end
    end

    always_comb
    begin
        case (in_sel)
            SEL_LENGTH:  in_range = in_tpos <= POS_W'(MAX_LEN);
            SEL_SYMBOL:  in_range = in_tpos < POS_W'(MAX_LEN);
            SEL_ERRSUM:  in_range = in_tpos < POS_W'(MAX_LEN);
            SEL_SCORE:   in_range = in_tpos < POS_W'(MAX_LEN) && in_col < 8'(N_THR);
            SEL_ERRPASS: in_range = in_tpos < POS_W'(MAX_LEN) && in_col < 8'(N_THR);
            SEL_CLIPPED: in_range = 1'b1;
            default:     in_range = 1'b0;
        endcase
    end

    always_comb
    begin
        lh_rd_addr  = in_tpos;
        sym_rd_addr = {in_tpos[ROW_W-1:0], in_col};
        if (is_sym)
        begin
            lh_rd_addr  = len;
            sym_rd_addr = {pos_row, in_sym};
        end
        else if (is_empty)
        begin
            lh_rd_addr = '0;
        end
        for (int b = 0; b < 2; b++)
        begin
            sbank_upd[b] = bank_pick(b[0], take && base_pos_reg != '0 && sfail != '0, prev_row,
                                     sfail, end_rd, len_row, take ? smask_new : smask_reg,
                                     in_tpos[ROW_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            base_pos_reg <= '0;
            min_reg      <= MIN_RESET;
            smask_reg    <= '1;
            clipped_reg  <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SYM_AW'(1);
                if (&clr_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (is_sym && clip)
            begin
                clipped_reg <= sat_inc(clipped_reg);
            end
            if (end_rd)
            begin
                base_pos_reg <= '0;
                min_reg      <= MIN_RESET;
                smask_reg    <= '1;
            end
            else if (take)
            begin
                base_pos_reg <= base_pos_reg + POS_W'(1);
                min_reg      <= min_new;
                smask_reg    <= smask_new;
            end
        end
    end

    rqsa_prob_rom u_prob_rom (
        .clk   (clk),
        .score (score_s),
        .prob  (prob)
    );

    // ------------------------------------------------------------------------
    // Stage one: symbol, length and score-threshold updates; running error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tbl_reg    <= 1'b0;
            s1_take_reg   <= 1'b0;
            s1_end_reg    <= 1'b0;
            s1_lh_inc_reg <= 1'b0;
            for (int b = 0; b < 2; b++)
            begin
                s1_sbank_reg[b] <= '0;
            end
            err_reg   <= '0;
            emask_reg <= '1;
        end
        else
        begin
            s1_tbl_reg    <= is_tbl;
            s1_take_reg   <= take;
            s1_end_reg    <= end_rd;
            s1_lh_inc_reg <= end_rd || is_empty;
            for (int b = 0; b < 2; b++)
            begin
                s1_sbank_reg[b] <= sbank_upd[b];
            end
            if (s1_end_reg)
            begin
                err_reg   <= '0;
                emask_reg <= '1;
            end
            else if (s1_take_reg)
            begin
                err_reg   <= e_new;
                emask_reg <= emask_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sel_reg      <= sel_t'(in_sel);
        s1_inr_reg      <= in_range;
        s1_col_reg      <= in_col[1:0];
        s1_tpos_row_reg <= in_tpos[ROW_W-1:0];
        s1_pos_row_reg  <= pos_row;
        s1_pos_nz_reg   <= base_pos_reg != '0;
        s1_len_row_reg  <= len_row;
        s1_lh_addr_reg  <= lh_rd_addr;
        s1_sym_addr_reg <= sym_rd_addr;
        s1_clip_reg     <= clipped_reg;
    end

    assign e_sum     = {1'b0, err_reg} + {1'b0, prob};
    assign e_new     = e_sum[ERR_W] ? ERR_MAX : e_sum[ERR_W-1:0];
    assign emask_new = emask_reg & below;
    assign efail     = emask_reg & ~emask_new;
    assign pes_rd_addr = s1_take_reg ? s1_pos_row_reg : s1_tpos_row_reg;

    always_comb
    begin
        for (int t = 0; t < N_THR; t++)
        begin
            below[t] = e_new <= ERR_THR[t];
        end
        for (int b = 0; b < 2; b++)
        begin
            ebank_upd[b] = bank_pick(b[0], s1_take_reg && s1_pos_nz_reg && efail != '0,
                                     ROW_W'(s1_pos_row_reg - ROW_W'(1)), efail, s1_end_reg,
                                     s1_len_row_reg, s1_take_reg ? emask_new : emask_reg,
                                     s1_tpos_row_reg);
        end
    end

    rqsa_ram #(.DEPTH(LH_DEPTH), .DW(CNT_W)) u_len_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (lh_rd_addr),
        .wr_en   (clearing_reg || s1_lh_inc_reg),
        .wr_addr (clearing_reg ? clr_cnt_reg[POS_W-1:0] : s1_lh_addr_reg),
        .wr_data (clearing_reg ? '0 : sat_inc(lh_rd)),
        .rd_data (lh_rd)
    );

    rqsa_ram #(.DEPTH(MAX_LEN * SYMBOL_COUNT), .DW(CNT_W)) u_sym_counts (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (sym_rd_addr),
        .wr_en   (clearing_reg || s1_take_reg),
        .wr_addr (clearing_reg ? clr_cnt_reg : s1_sym_addr_reg),
        .wr_data (clearing_reg ? '0 : sat_inc(sym_rd)),
        .rd_data (sym_rd)
    );

    rqsa_ram #(.DEPTH(MAX_LEN), .DW(CNT_W)) u_err_sums (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (pes_rd_addr),
        .wr_en   (clearing_reg || s2_pes_we_reg),
        .wr_addr (clearing_reg ? clr_cnt_reg[ROW_W-1:0] : s2_pes_addr_reg),
        .wr_data (clearing_reg ? '0 : pes_new),
        .rd_data (pes_rd)
    );

    for (genvar gb = 0; gb < 2; gb++)
    begin : g_bank
        rqsa_ram #(.DEPTH(BANK_DEPTH), .DW(LANE_W)) u_score_pass (
            .clk     (clk),
            .rst_n   (rst_n),
            .rd_addr (sbank_upd[gb].addr),
            .wr_en   (clearing_reg || s1_sbank_reg[gb].inc != '0),
            .wr_addr (clearing_reg ? clr_cnt_reg[BANK_AW-1:0] : s1_sbank_reg[gb].addr),
            .wr_data (clearing_reg ? '0 : inc_lanes(sb_rd[gb], s1_sbank_reg[gb].inc)),
            .rd_data (sb_rd[gb])
        );

        rqsa_ram #(.DEPTH(BANK_DEPTH), .DW(LANE_W)) u_err_pass (
            .clk     (clk),
            .rst_n   (rst_n),
            .rd_addr (ebank_upd[gb].addr),
            .wr_en   (clearing_reg || s2_ebank_reg[gb].inc != '0),
            .wr_addr (clearing_reg ? clr_cnt_reg[BANK_AW-1:0] : s2_ebank_reg[gb].addr),
            .wr_data (clearing_reg ? '0 : inc_lanes(eb_rd[gb], s2_ebank_reg[gb].inc)),
            .rd_data (eb_rd[gb])
        );
    end

    assign sb_sel = sb_rd[s1_tpos_row_reg[0]];

    always_comb
    begin
        case (s1_sel_reg)
            SEL_LENGTH:  early = lh_rd;
            SEL_SYMBOL:  early = sym_rd;
            SEL_SCORE:   early = sb_sel[s1_col_reg*CNT_W +: CNT_W];
            SEL_CLIPPED: early = s1_clip_reg;
            default:     early = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stage two: error sums and error-threshold updates; result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tbl_reg    <= 1'b0;
            s2_pes_we_reg <= 1'b0;
            for (int b = 0; b < 2; b++)
            begin
                s2_ebank_reg[b] <= '0;
            end
        end
        else
        begin
            s2_tbl_reg    <= s1_tbl_reg;
            s2_pes_we_reg <= s1_take_reg;
            for (int b = 0; b < 2; b++)
            begin
                s2_ebank_reg[b] <= ebank_upd[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sel_reg      <= s1_sel_reg;
        s2_inr_reg      <= s1_inr_reg;
        s2_col_reg      <= s1_col_reg;
        s2_trow0_reg    <= s1_tpos_row_reg[0];
        s2_early_reg    <= early;
        s2_pes_addr_reg <= pes_rd_addr;
        s2_err_reg      <= e_new;
    end

    assign pes_sum = {1'b0, pes_rd} + {17'd0, s2_err_reg};
    assign pes_new = pes_sum[CNT_W] ? '1 : pes_sum[CNT_W-1:0];
    assign eb_sel  = eb_rd[s2_trow0_reg];

    always_comb
    begin
        case (s2_sel_reg)
            SEL_ERRSUM:  result = pes_rd;
            SEL_ERRPASS: result = eb_sel[s2_col_reg*CNT_W +: CNT_W];
            default:     result = s2_early_reg;
        endcase
        if (!s2_inr_reg)
        begin
            result = '0;
        end
    end

    rqsa_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_tbl_reg),
        .push_data (result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .count     (fifo_count)
    );

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count == OUT_CW'(OUT_DEPTH)) |-> !s2_tbl_reg)
        else $error("result queue overflow");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_pos_reg <= POS_W'(MAX_LEN))
        else $error("base position beyond length limit");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_rd |=> (base_pos_reg == '0 && smask_reg == '1))
        else $error("read end did not clear per-read state");

    a_emask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        emask_reg == 4'b1111 || emask_reg == 4'b0111 || emask_reg == 4'b0011 ||
        emask_reg == 4'b0001 || emask_reg == 4'b0000)
        else $error("error threshold mask not contiguous");

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |=> (s1_tbl_reg == 1'b0 && s1_take_reg == 1'b0 && s1_lh_inc_reg == 1'b0))
        else $error("item taken during clearing pass");
`endif

endmodule

`default_nettype wire

[tb/read_quality_statistics_accumulator_tb.sv]
// ----------------------------------------------------------------------------
// Read quality statistics accumulator testbench
// Streams quality symbols, empty records and table reads into the block,
// predicts every table read from a behavioural copy of the statistics, and
// compares each returned item against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module read_quality_statistics_accumulator_tb;

    import rqsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 1200000;
    localparam int MAX_READ       = MAX_LEN;
    localparam logic [47:0] ERR_SAT = 48'hFFFF_FFFF_FFFF;

    localparam logic [63:0] DIGIT_TAB [10] = '{
        64'd1000000000000, 64'd794328234724, 64'd630957344480, 64'd501187233627,
        64'd398107170553, 64'd316227766017, 64'd251188643151, 64'd199526231497,
        64'd158489319246, 64'd125892541179
    };
    localparam int QUAL_LIMIT [4] = '{5, 10, 15, 20};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [63:0] expected_reads [$];
    int          mismatches;
    int          idle_cycles;
    bit          no_gaps;

    // Predicted block state.
    int          cur_offset;
    int          cur_pos;
    int          cur_min;
    logic [63:0] cur_err;
    int          score_left;
    int          err_left;
    logic [63:0] len_hist [0:MAX_LEN];
    logic [63:0] sym_counts [0:MAX_LEN*256-1];
    logic [63:0] err_sums [0:MAX_LEN-1];
    logic [63:0] score_last [0:MAX_LEN*4-1];
    logic [63:0] err_last [0:MAX_LEN*4-1];
    logic [63:0] clipped;

    read_quality_statistics_accumulator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // qual_char, table_select, table_position, table_column
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),  // req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),  // read_data
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] bump(input logic [63:0] x);
        return (&x) ? x : x + 64'd1;
    endfunction

    function automatic logic [47:0] error_of_score(input int s);
        logic [127:0] q;
        logic [127:0] den;
        logic [63:0]  z;
        int           k;
        int           r;
        int           m;
        int           n;
        if (s >= 0) begin
            k = s / 10;
            r = s % 10;
            q = (128'(DIGIT_TAB[r]) << 62) / 128'd1000000000000;
            if (q > (128'd1 << 62)) begin
                q = 128'd1 << 62;
            end
            z = q[63:0];
            for (int i = 0; i < k; i++) begin
                z = z / 64'd10;
            end
            z = (z + (64'd1 << 37)) >> 38;
            return z[47:0];
        end
        m = -s;
        n = (m + 9) / 10;
        r = 10 * n - m;
        if (n > 12) begin
            return ERR_SAT;
        end
        den = 128'd1;
        for (int i = 0; i < 12 - n; i++) begin
            den = den * 128'd10;
        end
        q = (128'(DIGIT_TAB[r]) << (PROB_FRAC_BITS + 1)) / den;
        if (q > (128'd1 << 50)) begin
            q = 128'd1 << 50;
        end
        q = (q + 128'd1) >> 1;
        return (q > 128'(ERR_SAT)) ? ERR_SAT : q[47:0];
    endfunction

    function automatic logic [63:0] error_limit(input int t);
        logic [63:0] one;
        one = 64'd1 << PROB_FRAC_BITS;
        case (t)
            0: return one;
            1: return one >> 1;
            2: return one >> 2;
            default: return (one + 64'd5) / 64'd10;
        endcase
    endfunction

    task automatic clear_read_state();
        cur_pos    = 0;
        cur_min    = 511;
        cur_err    = '0;
        score_left = 4;
        err_left   = 4;
    endtask

    task automatic account_symbol(input int sym);
        int score;
        score = sym - cur_offset;
        sym_counts[cur_pos*256 + sym] = bump(sym_counts[cur_pos*256 + sym]);
        if (score < cur_min) begin
            cur_min = score;
            while (score_left != 0 && cur_min <= QUAL_LIMIT[score_left-1]) begin
                score_left--;
                if (cur_pos != 0) begin
                    score_last[(cur_pos-1)*4 + score_left] =
                        bump(score_last[(cur_pos-1)*4 + score_left]);
                end
            end
        end
        cur_err = cur_err + 64'(error_of_score(score));
        if (cur_err > 64'(ERR_SAT)) begin
            cur_err = 64'(ERR_SAT);
        end
        err_sums[cur_pos] = (err_sums[cur_pos] > ~cur_err) ? '1 : err_sums[cur_pos] + cur_err;
        while (err_left != 0 && cur_err > error_limit(err_left - 1)) begin
            err_left--;
            if (cur_pos != 0) begin
                err_last[(cur_pos-1)*4 + err_left] = bump(err_last[(cur_pos-1)*4 + err_left]);
            end
        end
        cur_pos++;
    endtask

    task automatic close_read();
        len_hist[cur_pos] = bump(len_hist[cur_pos]);
        if (cur_pos != 0) begin
            for (int t = 0; t < score_left; t++) begin
                score_last[(cur_pos-1)*4 + t] = bump(score_last[(cur_pos-1)*4 + t]);
            end
            for (int t = 0; t < err_left; t++) begin
                err_last[(cur_pos-1)*4 + t] = bump(err_last[(cur_pos-1)*4 + t]);
            end
        end
        clear_read_state();
    endtask

    function automatic logic [63:0] table_entry(input int sel, input int pos, input int col);
        case (sel)
            SEL_LENGTH:  return (pos <= MAX_LEN) ? len_hist[pos] : '0;
            SEL_SYMBOL:  return (pos < MAX_LEN) ? sym_counts[pos*256 + col] : '0;
            SEL_ERRSUM:  return (pos < MAX_LEN) ? err_sums[pos] : '0;
            SEL_SCORE:   return (pos < MAX_LEN && col < 4) ? score_last[pos*4 + col] : '0;
            SEL_ERRPASS: return (pos < MAX_LEN && col < 4) ? err_last[pos*4 + col] : '0;
            SEL_CLIPPED: return clipped;
            default:     return '0;
        endcase
    endfunction

    task automatic predict_item(input req_t req, input int sym, input bit last,
                                input int sel, input int pos, input int col);
        case (req)
            REQ_SYMBOL:
            begin
                if (cur_pos < MAX_READ) begin
                    account_symbol(sym);
                end
                else begin
                    clipped = bump(clipped);
                end
                if (last) begin
                    close_read();
                end
            end
            REQ_EMPTY: len_hist[0] = bump(len_hist[0]);
            REQ_TABLE: expected_reads.push_back(table_entry(sel, pos, col));
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(input req_t req, input int sym, input bit last,
                             input int sel, input int pos, input int col);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = req;
        s_tlast  = last;
        s_tdata  = {2'b00, col[7:0], pos[10:0], sel[2:0], sym[7:0]};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_item(req, sym, last, sel, pos, col);
    endtask

    task automatic lower_valid();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic read_table(input int sel, input int pos, input int col);
        send_item(REQ_TABLE, $urandom_range(0, 255), $urandom_range(0, 1), sel, pos, col);
    endtask

    task automatic wait_drained();
        lower_valid();
        while (expected_reads.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_offset(input int value);
        wait_drained();
        @(negedge clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = {REG_ASCII_OFFSET, 2'b00};
        pwdata = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cur_offset = value & 127;
    endtask

    task automatic read_random_entry();
        int sel;
        int pos;
        int col;
        sel = $urandom_range(0, 9);
        if (sel > 7) begin
            sel = $urandom_range(SEL_SCORE, SEL_ERRPASS);
        end
        case ($urandom_range(0, 9))
            0: pos = $urandom_range(0, 2047);
            1: pos = $urandom_range(1020, 1025);
            default: pos = $urandom_range(0, 24);
        endcase
        col = (sel == SEL_SYMBOL || $urandom_range(0, 7) == 0) ?
              $urandom_range(0, 255) : $urandom_range(0, 3);
        read_table(sel, pos, col);
    endtask

    task automatic test_initial_tables();
        read_table(SEL_LENGTH, 0, 0);
        read_table(SEL_LENGTH, MAX_LEN, 255);
        read_table(SEL_LENGTH, MAX_LEN + 1, 0);
        read_table(SEL_SYMBOL, MAX_LEN - 1, 255);
        read_table(SEL_SYMBOL, MAX_LEN, 0);
        read_table(SEL_ERRSUM, 0, 0);
        read_table(SEL_SCORE, 0, 4);
        read_table(SEL_ERRPASS, 2047, 3);
        read_table(SEL_CLIPPED, 2047, 255);
        read_table(6, 0, 0);
        read_table(7, 5, 1);
        send_item(REQ_NONE, 255, 1, 7, 2047, 255);
    endtask

    task automatic test_special_reads();
        send_item(REQ_SYMBOL, 0, 1'b0, 0, 0, 0);
        send_item(REQ_SYMBOL, 255, 1'b0, 0, 0, 0);
        send_item(REQ_EMPTY, 0, 1'b0, 0, 0, 0);
        send_item(REQ_SYMBOL, 60, 1'b1, 0, 0, 0);
        send_item(REQ_SYMBOL, 73, 1'b0, 0, 0, 0);
        send_item(REQ_SYMBOL, 40, 1'b0, 0, 0, 0);
        send_item(REQ_SYMBOL, 34, 1'b1, 0, 0, 0);
        send_item(REQ_EMPTY, 0, 1'b1, 0, 0, 0);
        for (int p = 0; p < 3; p++) begin
            read_table(SEL_SYMBOL, p, p == 0 ? 0 : (p == 1 ? 40 : 34));
            read_table(SEL_ERRSUM, p, 0);
            read_table(SEL_SCORE, p, $urandom_range(0, 3));
            read_table(SEL_ERRPASS, p, $urandom_range(0, 3));
        end
        read_table(SEL_LENGTH, 0, 0);
        read_table(SEL_LENGTH, 3, 0);
    endtask

    task automatic test_offset_extremes();
        int offsets [3] = '{0, 127, 33};
        foreach (offsets[i]) begin
            write_offset(offsets[i]);
            send_item(REQ_SYMBOL, 127, 1'b0, 0, 0, 0);
            send_item(REQ_SYMBOL, 128, 1'b1, 0, 0, 0);
            read_table(SEL_ERRSUM, 1, 0);
            read_table(SEL_ERRPASS, 0, 0);
        end
    endtask

    task automatic test_clipping();
        for (int i = 0; i < MAX_LEN + 6; i++) begin
            send_item(REQ_SYMBOL, $urandom_range(50, 80), i == MAX_LEN + 5, 0, 0, 0);
        end
        read_table(SEL_CLIPPED, 0, 0);
        read_table(SEL_LENGTH, MAX_LEN, 0);
        read_table(SEL_SCORE, MAX_LEN - 1, 0);
        read_table(SEL_ERRSUM, MAX_LEN - 1, 0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int base;
        int rounds;
        sent   = 0;
        rounds = 0;
        while (sent < 120) begin
            if (rounds % 4 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 3))
                    0: write_offset(0);
                    1: write_offset(127);
                    2: write_offset(33);
                    default: write_offset($urandom_range(0, 127));
                endcase
            end
            case ($urandom_range(0, 9))
                0: read_random_entry();
                1: send_item(req_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                             $urandom_range(0, 1), $urandom_range(0, 7),
                             $urandom_range(0, 2047), $urandom_range(0, 255));
                default:
                begin
                    len  = $urandom_range(1, 20);
                    base = (cur_offset > 100) ? 128 : cur_offset;
                    for (int i = 0; i < len; i++) begin
                        send_item(REQ_SYMBOL,
                                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                                  base + $urandom_range(0, 45),
                                  i == len - 1, $urandom_range(0, 7),
                                  $urandom_range(0, 2047), $urandom_range(0, 255));
                    end
                    sent += len;
                    read_random_entry();
                end
            endcase
            sent++;
            rounds++;
        end
        lower_valid();
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = 1'b0;
            if (!no_gaps) begin
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_reads.size() == 0) begin
                report("unexpected read_data", m_tdata, '0);
            end
            else begin
                if (m_tdata !== expected_reads[0]) begin
                    report("read_data", m_tdata, expected_reads[0]);
                end
                void'(expected_reads.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("read_quality_statistics_accumulator_tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = REQ_NONE;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        cur_offset  = 33;
        clipped     = '0;
        clear_read_state();
        foreach (len_hist[i]) len_hist[i] = '0;
        foreach (sym_counts[i]) sym_counts[i] = '0;
        foreach (err_sums[i]) err_sums[i] = '0;
        foreach (score_last[i]) score_last[i] = '0;
        foreach (err_last[i]) err_last[i] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_initial_tables();
        test_special_reads();
        test_offset_extremes();
        test_clipping();
        test_random_traffic();
        while (expected_reads.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("read_quality_statistics_accumulator_tb passed");
        end
        else begin
            $display("read_quality_statistics_accumulator_tb failed");
        end
        $finish;
    end

endmodule
